FILE: hw/rtl/utf8_decode_line_wrap_assert.svh
// ----------------------------------------------------------------------------
// utf8_decode_line_wrap assertion macros
// Shared concurrent check forms for the decoder's modules.
// ----------------------------------------------------------------------------
`ifndef UTF8_DECODE_LINE_WRAP_ASSERT_SVH
`define UTF8_DECODE_LINE_WRAP_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define UDLW_ASSERT_HOLDS(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("udlw: check failed");

// Next-cycle implication, disabled in reset.
`define UDLW_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("udlw: check failed");

`endif

FILE: hw/rtl/udlw_pkg.sv
// ----------------------------------------------------------------------------
// udlw_pkg
// Types and constants shared by the UTF-8 row decoder modules.
// ----------------------------------------------------------------------------
package udlw_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_COLUMNS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_SIDE_MARGIN    = 1'b1;

    localparam logic [7:0] SCREEN_COLUMNS_RESET = 8'd80;
    localparam logic [5:0] SIDE_MARGIN_RESET    = 6'd5;

    localparam logic KIND_CHAR     = 1'b0;
    localparam logic KIND_LINE_END = 1'b1;

    typedef struct packed {
        logic [7:0] screen_columns;
        logic [5:0] side_margin;
    } udlw_cfg_t;

    // Work for one byte: optional wrap line end, optional character,
    // optional row line end, emitted in that order.
    typedef struct packed {
        logic        wrap;
        logic [7:0]  wrap_pad;
        logic        chr;
        logic [15:0] cp;
        logic        row;
        logic [7:0]  row_pad;
    } udlw_op_t;

endpackage

FILE: hw/rtl/udlw_front.sv
// ----------------------------------------------------------------------------
// udlw_front
// Decodes UTF-8 bytes, tracks segment columns and builds at most one op per byte.
// ----------------------------------------------------------------------------
`include "utf8_decode_line_wrap_assert.svh"

module udlw_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  udlw_pkg::udlw_cfg_t  cfg,
    input  logic                 push,
    input  logic                 q_full,
    input  logic [7:0]           text_byte,
    input  logic                 row_end,
    output logic                 op_push,
    output udlw_pkg::udlw_op_t   op
);
    import udlw_pkg::*;

    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_ONE  = 2'd1;
    localparam logic [1:0] PEND_TWO  = 2'd2;

    logic [1:0]  bytes_pending_reg, bytes_pending_next;
    logic [15:0] partial_code_reg, partial_code_next;
    logic [8:0]  column_count_reg, column_count_next;
    logic        segment_open_reg, segment_open_next;

    logic        accept;
    logic        have_cp;
    logic [15:0] cp;
    logic signed [9:0] lim_raw;
    logic [7:0]  limit;
    logic        wrap;
    logic [8:0]  count_a;
    logic [8:0]  count_b;
    logic        seg_b;
    logic        row_line;

    function automatic logic [7:0] pad_calc(input logic [7:0] cols,
                                            input logic [5:0] margin,
                                            input logic [8:0] count);
        logic signed [10:0] p;
        p = $signed({3'b000, cols}) - $signed({5'b00000, margin})
            - $signed({2'b00, count});
        pad_calc = (p < 0) ? 8'd0 : p[7:0];
    endfunction

    assign accept = push && !q_full;

    // byte decode
    always_comb
    begin
        bytes_pending_next = bytes_pending_reg;
        partial_code_next  = partial_code_reg;
        have_cp            = 1'b0;
        cp                 = '0;
        case (bytes_pending_reg)
            PEND_TWO:
            begin
                partial_code_next  = partial_code_reg | {4'b0000, text_byte[5:0], 6'b000000};
                bytes_pending_next = PEND_ONE;
            end
            PEND_ONE:
            begin
                cp                 = partial_code_reg | {10'b0, text_byte[5:0]};
                have_cp            = 1'b1;
                bytes_pending_next = PEND_NONE;
                partial_code_next  = '0;
            end
            default:
            begin
                // lead byte; anything not ASCII or 110xxxxx opens a 3-byte form
                if (!text_byte[7])
                begin
                    cp      = {8'b0, text_byte};
                    have_cp = 1'b1;
                end
                else if (text_byte[7:5] == 3'b110)
                begin
                    partial_code_next  = {5'b0, text_byte[4:0], 6'b000000};
                    bytes_pending_next = PEND_ONE;
                end
                else
                begin
                    partial_code_next  = {text_byte[3:0], 12'b0};
                    bytes_pending_next = PEND_TWO;
                end
            end
        endcase
        // row cut mid-sequence: flush with zero bits
        if (row_end && bytes_pending_next != PEND_NONE)
        begin
            cp                 = partial_code_next;
            have_cp            = 1'b1;
            bytes_pending_next = PEND_NONE;
            partial_code_next  = '0;
        end
    end

    // column accounting and wrap
    always_comb
    begin
        lim_raw = $signed({2'b00, cfg.screen_columns}) - $signed({3'b000, cfg.side_margin, 1'b0});
        limit   = (lim_raw < 10'sd1) ? 8'd1 : lim_raw[7:0];
        wrap    = have_cp && (column_count_reg >= {1'b0, limit});
        count_a = wrap ? 9'd0 : column_count_reg;
        seg_b   = wrap ? 1'b0 : segment_open_reg;
        count_b = count_a;
        if (have_cp)
        begin
            count_b = count_a + 9'd1 + ((cp == 16'h0009) ? 9'd3 : 9'd0)
                      + ((|cp[15:7]) ? 9'd1 : 9'd0);
            seg_b   = 1'b1;
        end
        row_line = row_end && seg_b;

        op.wrap     = wrap;
        op.wrap_pad = pad_calc(cfg.screen_columns, cfg.side_margin, column_count_reg);
        op.chr      = have_cp;
        op.cp       = cp;
        op.row      = row_line;
        op.row_pad  = pad_calc(cfg.screen_columns, cfg.side_margin, count_b);

        column_count_next = row_end ? 9'd0 : count_b;
        segment_open_next = row_end ? 1'b0 : seg_b;
    end

    assign op_push = accept && (wrap || have_cp || row_line);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_pending_reg <= PEND_NONE;
            partial_code_reg  <= '0;
            column_count_reg  <= '0;
            segment_open_reg  <= 1'b0;
        end
        else if (accept)
        begin
            bytes_pending_reg <= bytes_pending_next;
            partial_code_reg  <= partial_code_next;
            column_count_reg  <= column_count_next;
            segment_open_reg  <= segment_open_next;
        end
    end

    `UDLW_ASSERT_NEXT(a_row_end_clears, clk, rst_n, accept && row_end, column_count_reg == 9'd0 && !segment_open_reg && bytes_pending_reg == PEND_NONE)
    `UDLW_ASSERT_HOLDS(a_count_bounded, clk, rst_n, 1'b1, column_count_reg <= 9'd260)

endmodule

FILE: hw/rtl/udlw_queue.sv
// ----------------------------------------------------------------------------
// udlw_queue
// Short op queue between the decode front and the result back end.
// ----------------------------------------------------------------------------
`include "utf8_decode_line_wrap_assert.svh"

module udlw_queue #(
    parameter int DEPTH = udlw_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  udlw_pkg::udlw_op_t  wr_op,
    output logic                full,
    input  logic                rd_en,
    output logic                rd_valid,
    output udlw_pkg::udlw_op_t  rd_op
);
    import udlw_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    udlw_op_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_op    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_op;
        end
    end

    `UDLW_ASSERT_HOLDS(a_no_overflow, clk, rst_n, wr_en, !full || rd_en)
    `UDLW_ASSERT_HOLDS(a_no_underflow, clk, rst_n, rd_en, count_reg != '0)

endmodule

FILE: hw/rtl/udlw_back.sv
// ----------------------------------------------------------------------------
// udlw_back
// Expands each queued op into its result words through an output register.
// ----------------------------------------------------------------------------
`include "utf8_decode_line_wrap_assert.svh"

module udlw_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  udlw_pkg::udlw_op_t  q_op,
    output logic                q_pop,
    output logic                empty,
    input  logic                pop,
    output logic                kind,
    output logic [15:0]         code_point,
    output logic [7:0]          pad_count,
    output logic                last
);
    import udlw_pkg::*;

    // part bits: [0] wrap line end, [1] character, [2] row line end
    logic [2:0]  done_reg, done_next;
    logic        out_valid_reg, out_valid_next;
    logic        kind_reg;
    logic [15:0] code_point_reg;
    logic [7:0]  pad_count_reg;
    logic        last_reg;

    logic [2:0]  remaining;
    logic [2:0]  sel;
    logic        is_last;
    logic        load;

    always_comb
    begin
        remaining = {q_op.row, q_op.chr, q_op.wrap} & ~done_reg;
        if (remaining[0])
        begin
            sel = 3'b001;
        end
        else if (remaining[1])
        begin
            sel = 3'b010;
        end
        else
        begin
            sel = 3'b100;
        end
        is_last = ((remaining & ~sel) == 3'b000);
        load    = q_valid && (!out_valid_reg || pop);
        q_pop   = load && is_last;

        done_next = done_reg;
        if (load)
        begin
            done_next = is_last ? 3'b000 : (done_reg | sel);
        end

        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            last_reg <= is_last;
            if (sel[1])
            begin
                kind_reg       <= KIND_CHAR;
                code_point_reg <= q_op.cp;
                pad_count_reg  <= 8'd0;
            end
            else
            begin
                kind_reg       <= KIND_LINE_END;
                code_point_reg <= 16'd0;
                pad_count_reg  <= sel[0] ? q_op.wrap_pad : q_op.row_pad;
            end
        end
    end

    assign empty      = !out_valid_reg;
    assign kind       = kind_reg;
    assign code_point = code_point_reg;
    assign pad_count  = pad_count_reg;
    assign last       = last_reg;

    `UDLW_ASSERT_HOLDS(a_done_idle_clear, clk, rst_n, !q_valid, done_reg == 3'b000)

endmodule

FILE: hw/rtl/utf8_decode_line_wrap.sv
// ----------------------------------------------------------------------------
// utf8_decode_line_wrap
// UTF-8 row decoder to 16-bit code points with column count and line wrap.
// ----------------------------------------------------------------------------
// Takes one text byte per cycle while full is low. The front decodes the
// byte and settles the segment's column count in the same cycle, queuing at
// most one op per byte; a byte that only extends a sequence queues nothing.
// The back end turns each op into one to three result words (wrap line end,
// character, row line end) at one word per cycle through an output register
// while the result side pops, so sustained input rate is one byte per
// cycle as long as the result side drains as many words as bytes produce;
// otherwise the QUEUE_DEPTH-entry op queue fills and full rises. A byte's op
// is written into the op queue and then loaded into the output register, and
// its first result word can be popped once empty is low. Configuration writes
// are registered and apply to bytes taken after the write.
module utf8_decode_line_wrap #(
    parameter int QUEUE_DEPTH = udlw_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [udlw_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [udlw_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              push,
    output logic                              full,
    input  logic [7:0]                        text_byte,
    input  logic                              row_end,
    output logic                              empty,
    input  logic                              pop,
    output logic                              kind,
    output logic [15:0]                       code_point,
    output logic [7:0]                        pad_count,
    output logic                              last
);
    import udlw_pkg::*;

    udlw_cfg_t cfg_reg;
    logic      op_push;
    udlw_op_t  op;
    logic      q_valid;
    logic      q_pop;
    udlw_op_t  q_op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_columns <= SCREEN_COLUMNS_RESET;
            cfg_reg.side_margin    <= SIDE_MARGIN_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_SCREEN_COLUMNS: cfg_reg.screen_columns <= cfg_data[7:0];
                REG_SIDE_MARGIN:    cfg_reg.side_margin    <= cfg_data[5:0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    udlw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .push      (push),
        .q_full    (full),
        .text_byte (text_byte),
        .row_end   (row_end),
        .op_push   (op_push),
        .op        (op)
    );

    udlw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (op_push),
        .wr_op    (op),
        .full     (full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_op    (q_op)
    );

    udlw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_op       (q_op),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .kind       (kind),
        .code_point (code_point),
        .pad_count  (pad_count),
        .last       (last)
    );

endmodule

FILE: tb/utf8_decode_line_wrap_test.sv
// ----------------------------------------------------------------------------
// utf8_decode_line_wrap_test
// Self-checking bench for the UTF-8 row decoder with column count and wrap.
// A short table of directed bytes and register writes comes first. Random
// phases follow, each with its own screen setup: mostly well-formed 1-, 2-
// and 3-byte characters, plus stray bytes and rows cut inside a sequence.
// A behavioral decoder predicts words the table omits, and words are checked
// in order as they are popped. Input bursts and output stalls are random.
// ----------------------------------------------------------------------------
module utf8_decode_line_wrap_test;

    timeunit 1ns;
    timeprecision 1ps;

    import udlw_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [15:0] cp;
        logic [7:0]  pad;
        logic        last;
    } result_word_t;

    // One table row: a text byte (sel = row_end) or a register write
    // (sel = register index). n_typed > 0 gives the words to expect directly.
    typedef struct packed {
        logic         is_cfg;
        logic         sel;
        logic [7:0]   val;
        logic [1:0]   n_typed;
        result_word_t w0;
        result_word_t w1;
        result_word_t w2;
    } stim_t;

    localparam result_word_t NO_WORD = '0;
    localparam int NUM_DIRECTED = 25;
    localparam int NUM_PHASES = 6;

    function automatic result_word_t char_word(input logic [15:0] cp, input logic lst);
        return '{KIND_CHAR, cp, 8'd0, lst};
    endfunction

    function automatic result_word_t line_end_word(input logic [7:0] pad, input logic lst);
        return '{KIND_LINE_END, 16'd0, pad, lst};
    endfunction

    function automatic stim_t byte_row(input logic [7:0] b, input logic re, input logic [1:0] n,
                                       input result_word_t w0, input result_word_t w1,
                                       input result_word_t w2);
        return '{1'b0, re, b, n, w0, w1, w2};
    endfunction

    function automatic stim_t reg_row(input logic idx, input logic [7:0] data);
        return '{1'b1, idx, data, 2'd0, NO_WORD, NO_WORD, NO_WORD};
    endfunction

    // Reset setup: wrap limit 70, pad = 75 - columns.
    localparam stim_t DIRECTED [NUM_DIRECTED] = '{
        byte_row(8'h41, 1'b1, 2'd2, char_word(16'h0041, 1'b0), line_end_word(8'd74, 1'b1), NO_WORD),
        byte_row(8'h00, 1'b1, 2'd2, char_word(16'h0000, 1'b0), line_end_word(8'd74, 1'b1), NO_WORD),
        byte_row(8'h7F, 1'b0, 2'd1, char_word(16'h007F, 1'b1), NO_WORD, NO_WORD),
        byte_row(8'h09, 1'b0, 2'd1, char_word(16'h0009, 1'b1), NO_WORD, NO_WORD),
        byte_row(8'hC3, 1'b0, 2'd0, NO_WORD, NO_WORD, NO_WORD),
        byte_row(8'hA9, 1'b0, 2'd0, NO_WORD, NO_WORD, NO_WORD),
        byte_row(8'hE2, 1'b0, 2'd0, NO_WORD, NO_WORD, NO_WORD),
        byte_row(8'h82, 1'b0, 2'd0, NO_WORD, NO_WORD, NO_WORD),
        byte_row(8'hAC, 1'b0, 2'd0, NO_WORD, NO_WORD, NO_WORD),
        // 1111xxxx lead is a 3-byte lead
        byte_row(8'hFF, 1'b0, 2'd0, NO_WORD, NO_WORD, NO_WORD),
        byte_row(8'hBF, 1'b0, 2'd0, NO_WORD, NO_WORD, NO_WORD),
        byte_row(8'hBF, 1'b0, 2'd0, NO_WORD, NO_WORD, NO_WORD),
        // stray continuation as lead, continuation top bits unchecked
        byte_row(8'h80, 1'b0, 2'd0, NO_WORD, NO_WORD, NO_WORD),
        byte_row(8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD, NO_WORD),
        byte_row(8'h41, 1'b0, 2'd0, NO_WORD, NO_WORD, NO_WORD),
        // row ends inside a sequence
        byte_row(8'hDF, 1'b1, 2'd0, NO_WORD, NO_WORD, NO_WORD),
        byte_row(8'hEF, 1'b0, 2'd0, NO_WORD, NO_WORD, NO_WORD),
        byte_row(8'h80, 1'b1, 2'd0, NO_WORD, NO_WORD, NO_WORD),
        // narrow screen: limit 1, pad saturates at 0
        reg_row(REG_SCREEN_COLUMNS, 8'd8),
        reg_row(REG_SIDE_MARGIN, 8'd63),
        byte_row(8'h41, 1'b0, 2'd1, char_word(16'h0041, 1'b1), NO_WORD, NO_WORD),
        byte_row(8'hFF, 1'b1, 2'd3, line_end_word(8'd0, 1'b0), char_word(16'hF000, 1'b0),
                 line_end_word(8'd0, 1'b1)),
        // widest screen, no margin
        reg_row(REG_SCREEN_COLUMNS, 8'd255),
        reg_row(REG_SIDE_MARGIN, 8'd0),
        byte_row(8'h7E, 1'b1, 2'd2, char_word(16'h007E, 1'b0), line_end_word(8'd254, 1'b1),
                 NO_WORD)
    };

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   push = 1'b0;
    logic                   full;
    logic [7:0]             text_byte = 8'd0;
    logic                   row_end = 1'b0;
    logic                   empty;
    logic                   pop = 1'b0;
    logic                   kind;
    logic [15:0]            code_point;
    logic [7:0]             pad_count;
    logic                   last;

    utf8_decode_line_wrap uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .full       (full),
        .text_byte  (text_byte),
        .row_end    (row_end),
        .empty      (empty),
        .pop        (pop),
        .kind       (kind),
        .code_point (code_point),
        .pad_count  (pad_count),
        .last       (last)
    );

    // decoder model state
    logic [7:0]   screen_cols = SCREEN_COLUMNS_RESET;
    logic [5:0]   margin = SIDE_MARGIN_RESET;
    logic [1:0]   cont_left = '0;
    logic [15:0]  partial = '0;
    logic [8:0]   col_count = '0;
    logic         seg_open = 1'b0;

    result_word_t pending_words[$];
    bit           failed = 1'b0;
    int           burst_left = 0;
    logic [15:0]  stall_pat = '1;
    logic [3:0]   pat_pos = '0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [7:0] segment_pad();
        int p;
        p = int'(screen_cols) - int'(margin) - int'(col_count);
        return (p < 0) ? 8'd0 : 8'(p);
    endfunction

    // Decode one byte, update column state, return the words it produces.
    task automatic decode_byte(input logic [7:0] b, input logic re, output result_word_t res[$]);
        logic        have_cp;
        logic [15:0] cp;
        int          lim;
        have_cp = 1'b0;
        cp = '0;
        res = {};
        case (cont_left)
            2'd2:
            begin
                partial = partial | {4'd0, b[5:0], 6'd0};
                cont_left = 2'd1;
            end
            2'd1:
            begin
                cp = partial | {10'd0, b[5:0]};
                have_cp = 1'b1;
                cont_left = 2'd0;
                partial = '0;
            end
            default:
            begin
                if (!b[7])
                begin
                    cp = {8'd0, b};
                    have_cp = 1'b1;
                end
                else if (b[7:5] == 3'b110)
                begin
                    partial = {5'd0, b[4:0], 6'd0};
                    cont_left = 2'd1;
                end
                else
                begin
                    partial = {b[3:0], 12'd0};
                    cont_left = 2'd2;
                end
            end
        endcase
        // a row cut short fills the missing bits with zero
        if (re && cont_left != 2'd0)
        begin
            cp = partial;
            have_cp = 1'b1;
            cont_left = 2'd0;
            partial = '0;
        end
        if (have_cp)
        begin
            lim = int'(screen_cols) - 2 * int'(margin);
            if (lim < 1)
                lim = 1;
            if (int'(col_count) >= lim)
            begin
                res = {res, line_end_word(segment_pad(), 1'b0)};
                col_count = '0;
                seg_open = 1'b0;
            end
            col_count = col_count + 9'd1 + ((cp == 16'h0009) ? 9'd3 : 9'd0)
                        + ((cp > 16'd127) ? 9'd1 : 9'd0);
            seg_open = 1'b1;
            res = {res, char_word(cp, 1'b0)};
        end
        if (re)
        begin
            if (seg_open)
                res = {res, line_end_word(segment_pad(), 1'b0)};
            col_count = '0;
            seg_open = 1'b0;
        end
        if (res.size() > 0)
            res[res.size() - 1].last = 1'b1;
    endtask

    task automatic send_byte(input stim_t s);
        result_word_t res[$];
        int           gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        push <= 1'b1;
        text_byte <= s.val;
        row_end <= s.sel;
        do
            @(posedge clk);
        while (full);
        burst_left--;
        decode_byte(s.val, s.sel, res);
        if (s.n_typed != 2'd0)
        begin
            res = {s.w0, s.w1, s.w2};
            res = res[0:s.n_typed - 1];
        end
        foreach (res[i])
            pending_words = {pending_words, res[i]};
    endtask

    // Only written with nothing in flight.
    task automatic write_reg(input logic idx, input logic [7:0] data);
        push <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_SCREEN_COLUMNS)
            screen_cols = data;
        else
            margin = data[5:0];
    endtask

    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    // One character, stray byte, or cut-off sequence; counts bytes sent.
    task automatic send_char(input int row_odds, inout int sent);
        logic [7:0] seq[$];
        int         sel;
        logic       re;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            seq = {seq, (($urandom_range(0, 9) == 0) ? 8'h09 : 8'($urandom_range(0, 127)))};
        else if (sel < 60)
        begin
            seq = {seq, 8'hC0 | 8'($urandom_range(0, 31))};
            seq = {seq, cont_byte()};
        end
        else if (sel < 85)
        begin
            seq = {seq, 8'hE0 | 8'($urandom_range(0, 15))};
            seq = {seq, cont_byte()};
            seq = {seq, cont_byte()};
        end
        else
            seq = {seq, 8'($urandom_range(0, 255))};
        re = ($urandom_range(1, row_odds) == 1);
        if (re && seq.size() > 1 && $urandom_range(0, 2) == 0)
            seq = seq[0:$urandom_range(0, seq.size() - 2)];
        foreach (seq[i])
        begin
            send_byte(byte_row(seq[i], re && (i == seq.size() - 1), 2'd0,
                               NO_WORD, NO_WORD, NO_WORD));
            sent++;
        end
    endtask

    // result side: random stall pattern, refreshed each time the pattern position wraps
    always @(posedge clk)
    begin : drain_words
        result_word_t want;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (pending_words.size() == 0)
                begin
                    failed = 1'b1;
                    $error("unexpected word: kind %0d code_point %h pad_count %0d",
                           kind, code_point, pad_count);
                end
                else
                begin
                    want = pending_words.pop_front();
                    if (kind !== want.kind)
                    begin
                        failed = 1'b1;
                        $error("kind: expected %0d, got %0d", want.kind, kind);
                    end
                    if (code_point !== want.cp)
                    begin
                        failed = 1'b1;
                        $error("code_point: expected %h, got %h", want.cp, code_point);
                    end
                    if (pad_count !== want.pad)
                    begin
                        failed = 1'b1;
                        $error("pad_count: expected %0d, got %0d", want.pad, pad_count);
                    end
                    if (last !== want.last)
                    begin
                        failed = 1'b1;
                        $error("last: expected %0d, got %0d", want.last, last);
                    end
                end
            end
            if (pat_pos == 4'd0)
            begin
                case ($urandom_range(0, 3))
                    0: stall_pat = '1;
                    1: stall_pat = 16'h0001;
                    default: stall_pat = 16'($urandom);
                endcase
            end
            pop <= stall_pat[pat_pos];
            pat_pos = pat_pos + 4'd1;
        end
    end

    initial
    begin : stimulus
        int          sent;
        int          quota;
        int          row_odds;
        logic [7:0]  cols;
        logic [7:0]  marg;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            if (DIRECTED[i].is_cfg)
                write_reg(DIRECTED[i].sel, DIRECTED[i].val);
            else
                send_byte(DIRECTED[i]);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            quota = 20;
            row_odds = $urandom_range(2, 30);
            case (ph)
                0:
                begin
                    cols = 8'd255;
                    marg = 8'd0;
                end
                1:
                begin
                    cols = 8'd8;
                    marg = 8'd63;
                end
                2:
                begin
                    cols = 8'd8;
                    marg = 8'd0;
                end
                3:
                begin
                    cols = 8'd12;
                    marg = 8'd2;
                end
                4:
                begin
                    cols = 8'($urandom_range(8, 255));
                    marg = 8'($urandom_range(0, 63));
                end
                default:
                begin
                    // long rows so the 30-column limit wraps
                    cols = 8'd40;
                    marg = 8'd5;
                    quota = 30;
                    row_odds = 300;
                end
            endcase
            write_reg(REG_SCREEN_COLUMNS, cols);
            write_reg(REG_SIDE_MARGIN, marg);
            sent = 0;
            while (sent < quota)
                send_char(row_odds, sent);
        end

        push <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (!failed)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
